// ===== sv/itsn_pkg.sv =====
// shared widths, constants and types of the interval timer
`timescale 1ns / 1ps

package itsn_pkg;

    localparam int unsigned TICK_NS      = 10000000;
    localparam int unsigned SECOND_NS    = 1000000000;
    localparam int unsigned NSEC_MAX     = SECOND_NS - 1;
    localparam int unsigned MAX_LOAD_SEC = 100000000;

    localparam int SEC_W   = 27;
    localparam int NSEC_W  = 30;
    localparam int LSEC_W  = 32;
    localparam int LNSEC_W = 31;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // rounding datapath: value plus tick minus one stays below two seconds
    localparam int RND_W     = NSEC_W + 1;
    localparam int TICK_LOG  = $clog2(TICK_NS);
    localparam int RCP_SHIFT = RND_W + TICK_LOG;
    localparam int RCP_W     = RND_W + 2;
    localparam int PROD_W    = RND_W + RCP_W;
    localparam longint unsigned RCP_MULT =
        ((64'd1 << RCP_SHIFT) + 64'(TICK_NS) - 64'd1) / 64'(TICK_NS);

    localparam logic [ADDR_W-1:0] ADDR_INTERVAL_SEC  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_INTERVAL_NSEC = 3'd4;

    typedef enum logic
    {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t               func;
        logic                load_bad;
        logic [SEC_W-1:0]    load_sec;
        logic [RND_W-1:0]    load_quot;
        logic [NSEC_W-1:0]   amount;
    } stage_t;

endpackage

// ===== sv/interval_timer_sec_nsec_core.sv =====
// interval timer top level: request stage, tick/load update and result register
`timescale 1ns / 1ps

// One result per request, held in the result register after the request stage;
// a new request can be taken every cycle while no result waits on out_ready.
// Loads are range-checked and divided by the tick length with a reciprocal
// multiply while the request is registered; the update stage then rounds to a
// whole tick, or subtracts a tick amount with borrow and reload, and writes
// the timer state together with the result. The update of the remaining time
// sets the rate. remain_sec and remain_nsec show the timer state, which
// changes only when a new result is loaded.

module interval_timer_sec_nsec_core
    import itsn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      func,
    input  logic [NSEC_W-1:0]         amount_ns,
    input  logic signed [LSEC_W-1:0]  load_sec,
    input  logic signed [LNSEC_W-1:0] load_nsec,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      expired,
    output logic                      load_error,
    output logic [SEC_W-1:0]          remain_sec,
    output logic [NSEC_W-1:0]         remain_nsec,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    logic              s1_valid_reg;
    stage_t            s1_reg;
    stage_t            s1_next;
    logic              out_valid_reg;
    logic              expired_reg;
    logic              expired_next;
    logic              load_error_reg;
    logic              load_error_next;
    logic [SEC_W-1:0]  value_sec_reg;
    logic [SEC_W-1:0]  value_sec_next;
    logic [NSEC_W-1:0] value_nsec_reg;
    logic [NSEC_W-1:0] value_nsec_next;
    logic [SEC_W-1:0]  interval_sec_reg;
    logic [NSEC_W-1:0] interval_nsec_reg;

    logic              accept;
    logic              advance;
    logic              cfg_write;

    // request stage signals
    logic              sec_bad;
    logic              nsec_bad;
    logic [NSEC_W-1:0] nsec_raised;
    logic [RND_W-1:0]  rnd_in;
    logic [PROD_W-1:0] rcp_prod;

    // update stage signals
    logic [RND_W-1:0]  rounded;
    logic              idle;
    logic [RND_W-1:0]  diff;
    logic              diff_neg;
    logic              tick_expire;
    logic [NSEC_W-1:0] ival_nsec;
    logic [RND_W-1:0]  rl_sum;
    logic [NSEC_W-1:0] rl_nsec;
    logic [SEC_W-1:0]  rl_sec;
    logic              rl_under;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {{(DATA_W-NSEC_W){1'b0}}, interval_nsec_reg}
                                : {{(DATA_W-SEC_W){1'b0}}, interval_sec_reg};

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign out_valid   = out_valid_reg;
    assign expired     = expired_reg;
    assign load_error  = load_error_reg;
    assign remain_sec  = value_sec_reg;
    assign remain_nsec = value_nsec_reg;

    // request stage: range check, raise to one tick, divide by tick length, clamp tick amount
    always_comb
    begin
        sec_bad  = load_sec[LSEC_W-1] ||
                   (load_sec > $signed(LSEC_W'(MAX_LOAD_SEC)));
        nsec_bad = load_nsec[LNSEC_W-1] ||
                   (load_nsec[NSEC_W-1:0] > NSEC_W'(NSEC_MAX));
        nsec_raised = load_nsec[NSEC_W-1:0];
        if ((load_sec == '0) && (nsec_raised != '0) &&
            (nsec_raised < NSEC_W'(TICK_NS)))
        begin
            nsec_raised = NSEC_W'(TICK_NS);
        end
        rnd_in   = {1'b0, nsec_raised} + RND_W'(TICK_NS - 1);
        rcp_prod = PROD_W'(rnd_in) * PROD_W'(RCP_MULT);

        s1_next.func      = func_t'(func);
        s1_next.load_bad  = sec_bad || nsec_bad;
        s1_next.load_sec  = load_sec[SEC_W-1:0];
        s1_next.load_quot = RND_W'(rcp_prod >> RCP_SHIFT);
        s1_next.amount    = (amount_ns > NSEC_W'(NSEC_MAX)) ? NSEC_W'(NSEC_MAX)
                                                             : amount_ns;
    end

    // update stage: tick with borrow and reload, or rounded load
    always_comb
    begin
        rounded = s1_reg.load_quot * RND_W'(TICK_NS);

        idle        = (value_sec_reg == '0) && (value_nsec_reg == '0);
        diff        = {1'b0, value_nsec_reg} - {1'b0, s1_reg.amount};
        diff_neg    = diff[RND_W-1];
        tick_expire = !idle && (value_sec_reg == '0) && (diff_neg || (diff == '0));

        ival_nsec = (interval_nsec_reg > NSEC_W'(NSEC_MAX)) ? NSEC_W'(NSEC_MAX)
                                                             : interval_nsec_reg;
        rl_sum    = {1'b0, ival_nsec} + diff;
        rl_under  = 1'b0;
        if (rl_sum[RND_W-1])
        begin
            rl_nsec  = NSEC_W'(rl_sum + RND_W'(SECOND_NS));
            rl_sec   = interval_sec_reg - SEC_W'(1);
            rl_under = (interval_sec_reg == '0);
        end
        else
        begin
            rl_nsec = rl_sum[NSEC_W-1:0];
            rl_sec  = interval_sec_reg;
        end

        expired_next    = 1'b0;
        load_error_next = 1'b0;
        value_sec_next  = value_sec_reg;
        value_nsec_next = value_nsec_reg;

        case (s1_reg.func)
            FUNC_LOAD:
            begin
                if (s1_reg.load_bad)
                begin
                    load_error_next = 1'b1;
                end
                else if (rounded >= RND_W'(SECOND_NS))
                begin
                    value_nsec_next = NSEC_W'(rounded - RND_W'(SECOND_NS));
                    value_sec_next  = s1_reg.load_sec + SEC_W'(1);
                end
                else
                begin
                    value_nsec_next = rounded[NSEC_W-1:0];
                    value_sec_next  = s1_reg.load_sec;
                end
            end
            default:
            begin
                if (tick_expire)
                begin
                    expired_next = 1'b1;
                    if ((interval_sec_reg == '0) && (ival_nsec == '0))
                    begin
                        value_sec_next  = '0;
                        value_nsec_next = '0;
                    end
                    else if (rl_under || ((rl_sec == '0) && (rl_nsec == '0)))
                    begin
                        value_sec_next  = '0;
                        value_nsec_next = NSEC_W'(1);
                    end
                    else
                    begin
                        value_sec_next  = rl_sec;
                        value_nsec_next = rl_nsec;
                    end
                end
                else if (!idle)
                begin
                    if (diff_neg)
                    begin
                        value_nsec_next = NSEC_W'(diff + RND_W'(SECOND_NS));
                        value_sec_next  = value_sec_reg - SEC_W'(1);
                    end
                    else
                    begin
                        value_nsec_next = diff[NSEC_W-1:0];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            expired_reg       <= 1'b0;
            load_error_reg    <= 1'b0;
            value_sec_reg     <= '0;
            value_nsec_reg    <= '0;
            interval_sec_reg  <= '0;
            interval_nsec_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                expired_reg    <= expired_next;
                load_error_reg <= load_error_next;
                value_sec_reg  <= value_sec_next;
                value_nsec_reg <= value_nsec_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                if (paddr[2] == ADDR_INTERVAL_NSEC[2])
                begin
                    interval_nsec_reg <= pwdata[NSEC_W-1:0];
                end
                else
                begin
                    interval_sec_reg <= pwdata[SEC_W-1:0];
                end
            end
        end
    end

    // request payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the interval timer core
`timescale 1ns / 1ps

module testbench;
    import itsn_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_REQUESTS = 62;
    localparam longint TICK_L = longint'(TICK_NS);
    localparam longint SECOND_L = longint'(SECOND_NS);
    localparam longint NSEC_MAX_L = longint'(NSEC_MAX);
    localparam longint MAX_SEC_L = longint'(MAX_LOAD_SEC);

    typedef enum logic
    {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_t;

    typedef struct packed
    {
        logic              expired;
        logic              load_error;
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsec;
    } timer_result_t;

    typedef struct packed
    {
        row_kind_t           kind;
        func_t               op;
        logic [NSEC_W-1:0]   amount;
        logic [LSEC_W-1:0]   lsec;
        logic [LNSEC_W-1:0]  lnsec;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        logic                typed;
        timer_result_t       want;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid;
    logic                      in_ready;
    logic                      func;
    logic [NSEC_W-1:0]         amount_ns;
    logic signed [LSEC_W-1:0]  load_sec;
    logic signed [LNSEC_W-1:0] load_nsec;
    logic                      out_valid;
    logic                      out_ready;
    logic                      expired;
    logic                      load_error;
    logic [SEC_W-1:0]          remain_sec;
    logic [NSEC_W-1:0]         remain_nsec;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    // timer state and reload interval as the block should hold them
    logic [SEC_W-1:0]  timer_sec = '0;
    logic [NSEC_W-1:0] timer_nsec = '0;
    logic [SEC_W-1:0]  reload_sec = '0;
    logic [NSEC_W-1:0] reload_nsec = '0;

    timer_result_t pending_results[$];
    timer_result_t predicted;
    timer_result_t observed;
    timer_result_t oldest;
    logic          cur_typed = 1'b0;
    timer_result_t cur_want = '0;
    bit            in_steady = 1'b0;
    bit            out_steady = 1'b0;
    int            error_count = 0;
    int            cycle_count = 0;

    interval_timer_sec_nsec_core u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .amount_ns   (amount_ns),
        .load_sec    (load_sec),
        .load_nsec   (load_nsec),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .expired     (expired),
        .load_error  (load_error),
        .remain_sec  (remain_sec),
        .remain_nsec (remain_nsec),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic timer_result_t advance_timer(input func_t op,
                                                    input logic [NSEC_W-1:0] amt,
                                                    input logic signed [LSEC_W-1:0] lsec,
                                                    input logic signed [LNSEC_W-1:0] lnsec);
        timer_result_t res;
        longint        s;
        longint        n;
        longint        over;
        longint        step;
        longint        isec;
        longint        insec;
        bit            fire;
        res = '0;
        if (op == FUNC_LOAD)
        begin
            s = longint'(lsec);
            n = longint'(lnsec);
            if (s < 0 || s > MAX_SEC_L || n < 0 || n >= SECOND_L)
            begin
                res.load_error = 1'b1;
            end
            else
            begin
                if (s == 0 && n != 0 && n < TICK_L)
                    n = TICK_L;
                n = (n + TICK_L - 1) / TICK_L * TICK_L;
                if (n >= SECOND_L)
                begin
                    n -= SECOND_L;
                    s++;
                end
                timer_sec = s[SEC_W-1:0];
                timer_nsec = n[NSEC_W-1:0];
            end
        end
        else if (timer_sec != 0 || timer_nsec != 0)
        begin
            s = longint'(timer_sec);
            n = longint'(timer_nsec);
            over = 0;
            step = longint'(amt);
            if (step > NSEC_MAX_L)
                step = NSEC_MAX_L;
            n -= step;
            if (n < 0 && s == 0)
            begin
                over = n;
                fire = 1'b1;
            end
            else
            begin
                if (n < 0)
                begin
                    n += SECOND_L;
                    s--;
                end
                fire = (s == 0 && n == 0);
            end
            if (fire)
            begin
                isec = longint'(reload_sec);
                insec = longint'(reload_nsec);
                if (insec > NSEC_MAX_L)
                    insec = NSEC_MAX_L;
                // reload minus overshoot, kept armed at 1 ns when overdue
                if (isec != 0 || insec != 0)
                begin
                    insec += over;
                    if (insec < 0)
                    begin
                        insec += SECOND_L;
                        isec--;
                    end
                    if (isec < 0 || (isec == 0 && insec == 0))
                    begin
                        isec = 0;
                        insec = 1;
                    end
                end
                s = isec;
                n = insec;
            end
            timer_sec = s[SEC_W-1:0];
            timer_nsec = n[NSEC_W-1:0];
            res.expired = fire;
        end
        res.sec = timer_sec;
        res.nsec = timer_nsec;
        return res;
    endfunction

    function automatic stim_row_t tick_row(input longint amt);
        stim_row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.op = FUNC_TICK;
        r.amount = amt[NSEC_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t load_row(input longint s, input longint n);
        stim_row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.op = FUNC_LOAD;
        r.lsec = s[LSEC_W-1:0];
        r.lnsec = n[LNSEC_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.addr = a;
        r.data = d;
        return r;
    endfunction

    function automatic stim_row_t with_result(input stim_row_t r, input bit fired, input bit bad,
                                              input longint s, input longint n);
        stim_row_t t;
        t = r;
        t.typed = 1'b1;
        t.want.expired = fired;
        t.want.load_error = bad;
        t.want.sec = s[SEC_W-1:0];
        t.want.nsec = n[NSEC_W-1:0];
        return t;
    endfunction

    function automatic stim_row_t random_request();
        stim_row_t r;
        int        pick;
        r = '0;
        r.kind = ROW_REQ;
        r.amount = NSEC_W'($urandom());
        r.lsec = $urandom();
        r.lnsec = LNSEC_W'($urandom());
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
        begin
            r.op = FUNC_LOAD;
            // mostly legal values with short seconds so later ticks reach expiry
            if (pick >= 2)
            begin
                r.lsec = (pick < 8) ? $urandom_range(0, 2) : $urandom_range(0, MAX_LOAD_SEC);
                r.lnsec = $urandom_range(0, 1) ? LNSEC_W'($urandom_range(0, NSEC_MAX))
                                               : LNSEC_W'($urandom_range(0, TICK_NS));
            end
        end
        else
        begin
            r.op = FUNC_TICK;
            if (pick < 5)
                r.amount = NSEC_W'($urandom_range(0, 3 * TICK_NS));
            else if (pick < 9)
                r.amount = NSEC_W'($urandom_range(0, NSEC_MAX));
        end
        return r;
    endfunction

    task automatic send_request(input stim_row_t r);
        int gap;
        if ($urandom_range(0, 24) == 0)
            in_steady = !in_steady;
        gap = in_steady ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        func = r.op;
        amount_ns = r.amount;
        load_sec = r.lsec;
        load_nsec = r.lnsec;
        cur_typed = r.typed;
        cur_want = r.want;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_INTERVAL_SEC)
                    reload_sec = pwdata[SEC_W-1:0];
                else if (paddr == ADDR_INTERVAL_NSEC)
                    reload_nsec = pwdata[NSEC_W-1:0];
            end
            if (out_valid && out_ready)
            begin
                observed = {expired, load_error, remain_sec, remain_nsec};
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: exp=%0d err=%0d %0d s %0d ns",
                                 expired, load_error, remain_sec, remain_nsec);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (observed.expired !== oldest.expired
                        || observed.load_error !== oldest.load_error
                        || observed.sec !== oldest.sec
                        || observed.nsec !== oldest.nsec)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: expected exp=%0d err=%0d %0d s %0d ns, got exp=%0d err=%0d %0d s %0d ns",
                                     oldest.expired, oldest.load_error, oldest.sec, oldest.nsec,
                                     observed.expired, observed.load_error, observed.sec,
                                     observed.nsec);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predicted = advance_timer(func_t'(func), amount_ns, load_sec, load_nsec);
                pending_results.push_back(cur_typed ? cur_want : predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : result_sink
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                out_steady = !out_steady;
            gap = out_steady ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        stim_row_t        directed_rows[$];
        stim_row_t        row;
        logic [DATA_W-1:0] sec_word;
        logic [DATA_W-1:0] nsec_word;
        in_valid = 1'b0;
        func = FUNC_TICK;
        amount_ns = '0;
        load_sec = '0;
        load_nsec = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // idle timer, rejected loads, rounding, carry, saturation, reload cases
        directed_rows.push_back(with_result(tick_row(5), 0, 0, 0, 0));
        directed_rows.push_back(with_result(load_row(-1, 0), 0, 1, 0, 0));
        directed_rows.push_back(with_result(load_row(100000001, 0), 0, 1, 0, 0));
        directed_rows.push_back(with_result(load_row(0, -1), 0, 1, 0, 0));
        directed_rows.push_back(with_result(load_row(0, 1000000000), 0, 1, 0, 0));
        directed_rows.push_back(with_result(load_row(-2147483648, 0), 0, 1, 0, 0));
        directed_rows.push_back(with_result(load_row(0, -1073741824), 0, 1, 0, 0));
        directed_rows.push_back(with_result(load_row(0, 0), 0, 0, 0, 0));
        directed_rows.push_back(with_result(load_row(0, 1), 0, 0, 0, TICK_L));
        directed_rows.push_back(with_result(tick_row(NSEC_MAX_L), 1, 0, 0, 0));
        directed_rows.push_back(with_result(load_row(MAX_SEC_L, NSEC_MAX_L), 0, 0,
                                            MAX_SEC_L + 1, 0));
        directed_rows.push_back(with_result(load_row(1, 5), 0, 0, 1, TICK_L));
        directed_rows.push_back(with_result(tick_row(32'h3FFF_FFFF), 0, 0, 0, TICK_L + 1));
        directed_rows.push_back(with_result(tick_row(TICK_L + 1), 1, 0, 0, 0));
        directed_rows.push_back(with_result(load_row(2147483647, 1073741823), 0, 1, 0, 0));
        directed_rows.push_back(with_result(load_row(3, 990000001), 0, 0, 4, 0));
        directed_rows.push_back(with_result(tick_row(0), 0, 0, 4, 0));
        directed_rows.push_back(cfg_row(ADDR_INTERVAL_NSEC, 32'h3FFF_FFFF));
        directed_rows.push_back(cfg_row(ADDR_INTERVAL_SEC, 32'd0));
        directed_rows.push_back(with_result(load_row(0, 5), 0, 0, 0, TICK_L));
        directed_rows.push_back(with_result(tick_row(3 * TICK_L), 1, 0, 0, 979999999));
        directed_rows.push_back(tick_row(979999999));
        directed_rows.push_back(cfg_row(ADDR_INTERVAL_NSEC, 32'd5));
        directed_rows.push_back(with_result(load_row(0, 1), 0, 0, 0, TICK_L));
        directed_rows.push_back(with_result(tick_row(NSEC_MAX_L), 1, 0, 0, 1));
        directed_rows.push_back(with_result(tick_row(1), 1, 0, 0, 5));
        directed_rows.push_back(cfg_row(ADDR_INTERVAL_SEC, 32'hFFFF_FFFF));
        directed_rows.push_back(tick_row(7));
        directed_rows.push_back(with_result(load_row(MAX_SEC_L, 0), 0, 0, MAX_SEC_L, 0));

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                apb_write(row.addr, row.data);
            end
            else
            begin
                send_request(row);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    sec_word = '0;
                    nsec_word = '0;
                end
                1:
                begin
                    sec_word = '1;
                    nsec_word = '1;
                end
                2:
                begin
                    sec_word = MAX_LOAD_SEC;
                    nsec_word = NSEC_MAX;
                end
                3:
                begin
                    sec_word = '0;
                    nsec_word = 32'd1;
                end
                default:
                begin
                    // short intervals, sometimes with junk above the register width
                    sec_word = $urandom_range(0, 2);
                    nsec_word = $urandom_range(0, NSEC_MAX);
                    if ($urandom_range(0, 1) == 1)
                        sec_word[DATA_W-1:SEC_W] = (DATA_W-SEC_W)'($urandom());
                    if ($urandom_range(0, 1) == 1)
                        nsec_word[DATA_W-1:NSEC_W] = (DATA_W-NSEC_W)'($urandom());
                end
            endcase
            wait_idle();
            apb_write(ADDR_INTERVAL_SEC, sec_word);
            apb_write(ADDR_INTERVAL_NSEC, nsec_word);
            repeat (PHASE_REQUESTS) send_request(random_request());
        end

        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
